@@ hw/rtl/tpag_pkg.sv @@
// shared constants, register indexes, state codes and helpers for the permute address generator
`default_nettype none

package tpag_pkg;

  // dimension bookkeeping (four extent registers, two-bit axis codes)
  localparam int MAX_DIMS    = 4;
  localparam int DIM_IDX_W   = 2;
  localparam int DIM_COUNT_W = 3;
  localparam int AXIS_W      = 2;
  localparam int AXIS_ORDER_W = MAX_DIMS * AXIS_W;

  // extent registers and per-dimension counters
  localparam int SIZE_W      = 25;
  localparam int CNT_W       = 24;
  localparam int OUT_INDEX_W = 24;

  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(1) << CNT_W;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = SIZE_W;

  localparam logic [CFG_INDEX_W-1:0] REG_DIM_COUNT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_DIM0  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_DIM1  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_DIM2  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_DIM3  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_ORDER = 3'd5;

  // register reset values
  localparam logic [DIM_COUNT_W-1:0]  DIM_COUNT_RST  = 3'd1;
  localparam logic [SIZE_W-1:0]       SIZE_RST       = 25'd1;
  localparam logic [AXIS_ORDER_W-1:0] AXIS_ORDER_RST = 8'd228;

  // plan builder states
  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_STRIDE = 6'b000010,
    ST_WRAP   = 6'b000100,
    ST_JUMP   = 6'b001000,
    ST_FINAL  = 6'b010000,
    ST_RUN    = 6'b100000
  } plan_state_t;

  // zero extent reads as one, extents above the cap saturate
  function automatic logic [SIZE_W-1:0] clamp_extent(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_CAP) begin
      r = SIZE_CAP;
    end
    return r;
  endfunction

  // input dimension named at output position p
  function automatic logic [AXIS_W-1:0] axis_at(input logic [AXIS_ORDER_W-1:0] order,
                                                input logic [DIM_IDX_W-1:0] p);
    return order[{p, 1'b0} +: AXIS_W];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tpag_plan.sv @@
// configuration registers and the multi-cycle builder of strides and index jumps
`default_nettype none

module tpag_plan #(
  parameter int INDEX_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tpag_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tpag_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               busy,
  output logic [tpag_pkg::CNT_W-1:0]         ext_m1 [tpag_pkg::MAX_DIMS],
  output logic [INDEX_BITS-1:0]              jump [tpag_pkg::MAX_DIMS],
  output logic [INDEX_BITS-1:0]              jump_all
);

  import tpag_pkg::*;

  logic [DIM_COUNT_W-1:0]  dim_count;
  logic [SIZE_W-1:0]       size_dim [MAX_DIMS];
  logic [AXIS_ORDER_W-1:0] axis_order;

  plan_state_t state;
  plan_state_t state_next;

  logic [DIM_IDX_W-1:0]  pos;
  logic [DIM_IDX_W-1:0]  dsel;
  logic [INDEX_BITS-1:0] acc;
  logic [INDEX_BITS-1:0] strides [MAX_DIMS];
  logic [INDEX_BITS-1:0] wrap_back [MAX_DIMS];
  logic [CNT_W-1:0]      ext_m1_r [MAX_DIMS];

  logic                  cfg_wr;
  logic                  rebuild_req;
  logic [DIM_COUNT_W-1:0] n_used;
  logic [SIZE_W-1:0]     ext_all [MAX_DIMS];
  logic [CNT_W-1:0]      ext_m1_c [MAX_DIMS];
  logic [AXIS_W-1:0]     inner_ax;
  logic [AXIS_W-1:0]     ax_a;
  logic [AXIS_W-1:0]     ax_b;
  logic [INDEX_BITS-1:0] mul_a;
  logic [INDEX_BITS-1:0] mul_b;
  logic [INDEX_BITS-1:0] prod;

  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign rebuild_req = cfg_wr && (cfg_index <= REG_AXIS_ORDER);
  assign busy        = (state != ST_RUN);

  // dimensions in use and effective extents
  always_comb begin
    if (dim_count == '0) begin
      n_used = DIM_COUNT_W'(1);
    end else if (dim_count > DIM_COUNT_W'(MAX_DIMS)) begin
      n_used = DIM_COUNT_W'(MAX_DIMS);
    end else begin
      n_used = dim_count;
    end
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (DIM_COUNT_W'(d) < n_used) begin
        ext_all[d] = clamp_extent(size_dim[d]);
      end else begin
        ext_all[d] = SIZE_W'(1);
      end
      ext_m1_c[d] = CNT_W'(ext_all[d] - SIZE_W'(1));
    end
  end

  // axis lookups for the stride chain
  assign inner_ax = axis_at(axis_order, DIM_IDX_W'(n_used - DIM_COUNT_W'(1)));
  assign ax_a     = axis_at(axis_order, pos);
  assign ax_b     = axis_at(axis_order, pos + DIM_IDX_W'(1));

  // one shared multiplier, truncated to the index width
  always_comb begin
    if (state == ST_STRIDE) begin
      mul_a = strides[ax_b];
      mul_b = INDEX_BITS'(ext_all[ax_b]);
    end else begin
      mul_a = strides[dsel];
      mul_b = INDEX_BITS'(ext_m1_c[dsel]);
    end
  end

  assign prod = mul_a * mul_b;

  // builder sequencing
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:   state_next = (n_used > DIM_COUNT_W'(1)) ? ST_STRIDE : ST_WRAP;
      ST_STRIDE: state_next = (pos == '0) ? ST_WRAP : ST_STRIDE;
      ST_WRAP:   state_next = (dsel == '0) ? ST_JUMP : ST_WRAP;
      ST_JUMP:   state_next = (dsel == '0) ? ST_FINAL : ST_JUMP;
      ST_FINAL:  state_next = ST_RUN;
      ST_RUN:    state_next = ST_RUN;
      default:   state_next = ST_INIT;
    endcase
    if (rebuild_req) begin
      state_next = ST_INIT;
    end
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      dim_count  <= DIM_COUNT_RST;
      axis_order <= AXIS_ORDER_RST;
      for (int d = 0; d < MAX_DIMS; d++) begin
        size_dim[d] <= SIZE_RST;
      end
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_DIM_COUNT:  dim_count   <= cfg_data[DIM_COUNT_W-1:0];
          REG_SIZE_DIM0:  size_dim[0] <= cfg_data;
          REG_SIZE_DIM1:  size_dim[1] <= cfg_data;
          REG_SIZE_DIM2:  size_dim[2] <= cfg_data;
          REG_SIZE_DIM3:  size_dim[3] <= cfg_data;
          REG_AXIS_ORDER: axis_order  <= cfg_data[AXIS_ORDER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // plan datapath: strides, wrap-back amounts, then per-dimension jumps
  always_ff @(posedge clk) begin
    case (state)
      ST_INIT: begin
        // innermost named dimension starts the chain with stride one
        for (int d = 0; d < MAX_DIMS; d++) begin
          strides[d]  <= (AXIS_W'(d) == inner_ax) ? INDEX_BITS'(1) : '0;
          ext_m1_r[d] <= ext_m1_c[d];
        end
        pos  <= DIM_IDX_W'(n_used - DIM_COUNT_W'(2));
        dsel <= DIM_IDX_W'(MAX_DIMS - 1);
        acc  <= '0;
      end
      ST_STRIDE: begin
        strides[ax_a] <= prod;
        pos <= pos - DIM_IDX_W'(1);
      end
      ST_WRAP: begin
        wrap_back[dsel] <= prod;
        dsel <= dsel - DIM_IDX_W'(1);
      end
      ST_JUMP: begin
        jump[dsel] <= strides[dsel] - acc;
        acc  <= acc + wrap_back[dsel];
        dsel <= dsel - DIM_IDX_W'(1);
      end
      ST_FINAL: begin
        jump_all <= '0 - acc;
      end
      default: ;
    endcase
  end

  assign ext_m1 = ext_m1_r;

  // a register write always restarts the builder
  a_write_restarts: assert property (@(posedge clk) disable iff (rst)
    rebuild_req |=> state == ST_INIT)
    else $error("register write did not restart plan build");

  // the builder ends in the run state
  a_final_to_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL) && !rebuild_req |=> !busy)
    else $error("plan build did not finish");

endmodule

`default_nettype wire

@@ hw/rtl/tpag_odometer.sv @@
// per-dimension counter chain and running output index
`default_nettype none

module tpag_odometer #(
  parameter int INDEX_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        busy,
  input  logic                        advance,
  input  logic [tpag_pkg::CNT_W-1:0]  ext_m1 [tpag_pkg::MAX_DIMS],
  input  logic [INDEX_BITS-1:0]       jump [tpag_pkg::MAX_DIMS],
  input  logic [INDEX_BITS-1:0]       jump_all,
  output logic [INDEX_BITS-1:0]       cur_index,
  output logic                        last
);

  import tpag_pkg::*;

  logic [CNT_W-1:0]      cnt [MAX_DIMS];
  logic [MAX_DIMS-1:0]   at_max;
  logic [MAX_DIMS-1:0]   bump;
  logic [MAX_DIMS:0]     carry;
  logic [MAX_DIMS-1:0]   cnt_zero;
  logic [INDEX_BITS-1:0] step;

  // carry ripples from the innermost dimension outward
  always_comb begin
    carry[MAX_DIMS] = 1'b1;
    step = jump_all;
    for (int d = MAX_DIMS - 1; d >= 0; d--) begin
      at_max[d]   = (cnt[d] == ext_m1[d]);
      bump[d]     = carry[d+1] && !at_max[d];
      carry[d]    = carry[d+1] && at_max[d];
      cnt_zero[d] = (cnt[d] == '0);
    end
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (bump[d]) begin
        step = jump[d];
      end
    end
  end

  assign last = carry[0];

  // counters and index, held at the tensor start while the plan is rebuilt
  always_ff @(posedge clk) begin
    if (rst || busy) begin
      cur_index <= '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
        cnt[d] <= '0;
      end
    end else if (advance) begin
      cur_index <= cur_index + step;
      for (int d = 0; d < MAX_DIMS; d++) begin
        if (carry[d+1]) begin
          cnt[d] <= at_max[d] ? '0 : cnt[d] + CNT_W'(1);
        end
      end
    end
  end

  // the element after the final one starts a fresh tensor
  a_wrap_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && last |=> (&cnt_zero) && (cur_index == '0))
    else $error("odometer did not wrap after last element");

  // rebuild leaves the odometer at the origin
  a_busy_origin: assert property (@(posedge clk) disable iff (rst)
    busy |=> (&cnt_zero) && (cur_index == '0))
    else $error("odometer not cleared during rebuild");

endmodule

`default_nettype wire

@@ hw/rtl/tensor_permute_address_generator_top.sv @@
// top level of the tensor permute address generator
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata: in_data
//  m_*      out  m_tvalid/m_tready    m_tdata: out_data, out_index; m_tlast: last_element
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one element beat per clock while the builder is idle and no output stall holds it;
// each result is registered in the output register in the cycle after its input beat,
// with the index read from the running odometer register. after reset and after each
// register write the plan builder runs (stride chain, then wrap-back products, then
// jumps) with s_tready low.
// the output register lets a new beat in while the held result is taken in the same cycle.
`default_nettype none

module tensor_permute_address_generator_top #(
  parameter int DATA_BITS  = 32,
  parameter int INDEX_BITS = 24,
  localparam int IN_W  = ((DATA_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((DATA_BITS + tpag_pkg::OUT_INDEX_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [IN_W-1:0]                   s_tdata,   // in_data
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [OUT_W-1:0]                  m_tdata,   // out_data, out_index
  output logic                              m_tlast,   // last_element
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpag_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tpag_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import tpag_pkg::*;

  logic                   busy;
  logic [CNT_W-1:0]       ext_m1 [MAX_DIMS];
  logic [INDEX_BITS-1:0]  jump [MAX_DIMS];
  logic [INDEX_BITS-1:0]  jump_all;
  logic [INDEX_BITS-1:0]  cur_index;
  logic                   last;
  logic                   in_accept;

  logic [DATA_BITS-1:0]   out_data;
  logic [OUT_INDEX_W-1:0] out_index;

  // configuration and plan
  tpag_plan #(
    .INDEX_BITS (INDEX_BITS)
  ) u_plan (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .ext_m1    (ext_m1),
    .jump      (jump),
    .jump_all  (jump_all)
  );

  // position tracking
  tpag_odometer #(
    .INDEX_BITS (INDEX_BITS)
  ) u_odometer (
    .clk       (clk),
    .rst       (rst),
    .busy      (busy),
    .advance   (in_accept),
    .ext_m1    (ext_m1),
    .jump      (jump),
    .jump_all  (jump_all),
    .cur_index (cur_index),
    .last      (last)
  );

  // input handshake
  assign s_tready  = !busy && (!m_tvalid || m_tready);
  assign in_accept = s_tvalid && s_tready;

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data  <= s_tdata[DATA_BITS-1:0];
      out_index <= OUT_INDEX_W'(cur_index);
      m_tlast   <= last;
    end
  end

  assign m_tdata = OUT_W'({out_index, out_data});

  // an accepted element shows up unchanged in the next output beat
  a_data_passes: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> m_tvalid && (out_data == $past(s_tdata[DATA_BITS-1:0])))
    else $error("element not forwarded to output register");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the tensor permute address generator top level
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tpag_pkg::*;

  localparam int DATA_W = 32;
  localparam int IDX_W  = OUT_INDEX_W;
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_BEATS = 500;
  localparam int CALM_AFTER = 440;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  index;
    logic              last;
  } placed_elem_t;

  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] reg_sel;
    logic [31:0]            value;
    logic                   typed;
    logic [IDX_W-1:0]       want_index;
    logic                   want_last;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [31:0]            s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [55:0]            m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // shadow registers and odometer state of the address generator
  logic [DIM_COUNT_W-1:0]  cfg_dims;
  logic [SIZE_W-1:0]       size_reg [4];
  logic [AXIS_ORDER_W-1:0] cfg_axis;
  logic [IDX_W-1:0]        odo [4];
  logic [IDX_W-1:0]        stride [4];
  logic [IDX_W-1:0]        out_pos;

  placed_elem_t awaited[$];
  stim_row_t    directed_rows[$];
  int           mismatch_count;
  bit           drain_hold_req;
  bit           calm_tail;
  bit           idle_on;

  tensor_permute_address_generator_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // dimension count as the hardware uses it
  function automatic int dims_in_use();
    int n;
    n = cfg_dims;
    if (n < 1) n = 1;
    if (n > 4) n = 4;
    return n;
  endfunction

  // effective extent: unused dims are 1, zero reads as 1, large values saturate
  function automatic logic [SIZE_W-1:0] extent_of_dim(int d);
    logic [SIZE_W-1:0] s;
    s = size_reg[d];
    if (d >= dims_in_use()) return SIZE_W'(1);
    if (s == '0) s = SIZE_W'(1);
    else if (s > SIZE_CAP) s = SIZE_CAP;
    return s;
  endfunction

  // output strides from the axis order, innermost position first; restarts the tensor
  function automatic void build_strides();
    int n;
    int p;
    logic [AXIS_W-1:0] a;
    logic [AXIS_W-1:0] b;
    logic [63:0] prod;
    n = dims_in_use();
    for (int d = 0; d < 4; d++) begin
      stride[d] = '0;
      odo[d] = '0;
    end
    out_pos = '0;
    stride[cfg_axis[2*(n-1) +: 2]] = IDX_W'(1);
    for (p = n - 2; p >= 0; p--) begin
      a = cfg_axis[2*p +: 2];
      b = cfg_axis[2*p+2 +: 2];
      prod = 64'(stride[b]) * 64'(extent_of_dim(b));
      stride[a] = prod[IDX_W-1:0];
    end
  endfunction

  // register write as the block sees it
  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] sel, logic [SIZE_W-1:0] val);
    case (sel)
      REG_DIM_COUNT:  cfg_dims = val[DIM_COUNT_W-1:0];
      REG_SIZE_DIM0:  size_reg[0] = val;
      REG_SIZE_DIM1:  size_reg[1] = val;
      REG_SIZE_DIM2:  size_reg[2] = val;
      REG_SIZE_DIM3:  size_reg[3] = val;
      REG_AXIS_ORDER: cfg_axis = val[AXIS_ORDER_W-1:0];
      default:        return;
    endcase
    build_strides();
  endfunction

  // place one element, then step the odometer innermost dimension first
  function automatic placed_elem_t place_element(logic [DATA_W-1:0] data);
    placed_elem_t r;
    logic [SIZE_W-1:0] ext;
    logic [SIZE_W-1:0] nxt;
    logic [IDX_W-1:0] st;
    logic [63:0] span;
    bit carry;
    r.data = data;
    r.index = out_pos;
    r.last = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if ({1'b0, odo[k]} != extent_of_dim(k) - SIZE_W'(1)) r.last = 1'b0;
    end
    carry = 1'b1;
    for (int d = 3; d >= 0; d--) begin
      if (carry) begin
        ext = extent_of_dim(d);
        st = stride[d];
        nxt = {1'b0, odo[d]} + SIZE_W'(1);
        out_pos = out_pos + st;
        if (nxt < ext) begin
          odo[d] = nxt[IDX_W-1:0];
          carry = 1'b0;
        end else begin
          odo[d] = '0;
          span = 64'(st) * 64'(ext);
          out_pos = out_pos - span[IDX_W-1:0];
        end
      end
    end
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_INDEX_W-1:0] sel, logic [31:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.reg_sel = sel;
    r.value = val;
    return r;
  endfunction

  function automatic stim_row_t elem_row(logic [31:0] data, bit typed,
                                         logic [IDX_W-1:0] idx, bit last);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.value = data;
    r.typed = typed;
    r.want_index = idx;
    r.want_last = last;
    return r;
  endfunction

  // append one row to the directed table
  function automatic void add_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // mostly tiny extents, some zero, saturating and mid-size ones for stride wrap
  function automatic logic [SIZE_W-1:0] rand_extent();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return SIZE_W'($urandom_range(1, 4));
    if (r < 15) return '0;
    if (r < 17) return SIZE_W'($urandom_range(5, 16));
    if (r == 17) return SIZE_CAP;
    if (r == 18) return SIZE_W'($urandom_range(32'h100_0001, 32'h1FF_FFFF));
    return SIZE_W'($urandom_range(100, 5000));
  endfunction

  function automatic logic [SIZE_W-1:0] rand_dims();
    if ($urandom_range(0, 19) < 16) return SIZE_W'($urandom_range(1, 4));
    return SIZE_W'($urandom_range(0, 7));
  endfunction

  // mostly true permutations, sometimes any byte
  function automatic logic [SIZE_W-1:0] rand_axis();
    int perm [4];
    int j;
    int t;
    logic [AXIS_ORDER_W-1:0] v;
    if ($urandom_range(0, 3) == 0) return SIZE_W'($urandom_range(0, 255));
    for (int i = 0; i < 4; i++) perm[i] = i;
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < 4; i++) v[2*i +: 2] = perm[i][1:0];
    return SIZE_W'(v);
  endfunction

  // config beat, only once every pending result has drained
  task automatic write_reg(logic [CFG_INDEX_W-1:0] sel, logic [SIZE_W-1:0] val);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = sel;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(sel, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one element beat; typed rows override the predicted index and last flag
  task automatic offer(logic [DATA_W-1:0] data, bit typed, logic [IDX_W-1:0] idx, bit last);
    placed_elem_t p;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    p = place_element(data);
    if (typed) begin
      p.index = idx;
      p.last = last;
    end
    awaited.insert(awaited.size(), p);
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(1, 12);
    @(negedge clk);
    s_tvalid = 1'b0;
    s_tdata = $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  // sink side: random stall bursts and the one long hold-off
  initial begin : sink
    int gap;
    forever begin
      @(negedge clk);
      if (drain_hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        drain_hold_req = 1'b0;
      end else if (idle_on && !calm_tail && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 12);
        m_tready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // result checker against the oldest pending element
  always @(posedge clk) begin : check_out
    placed_elem_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result beat: data %h index %h last %b",
                 $time, m_tdata[31:0], m_tdata[55:32], m_tlast);
      end else begin
        want = awaited.pop_front();
        if (m_tdata[31:0] !== want.data) begin
          mismatch_count++;
          $display("%0t out_data mismatch: expected %h actual %h",
                   $time, want.data, m_tdata[31:0]);
        end
        if (m_tdata[55:32] !== want.index) begin
          mismatch_count++;
          $display("%0t out_index mismatch: expected %h actual %h",
                   $time, want.index, m_tdata[55:32]);
        end
        if (m_tlast !== want.last) begin
          mismatch_count++;
          $display("%0t last_element mismatch: expected %b actual %b",
                   $time, want.last, m_tlast);
        end
      end
    end
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("FAIL tensor_permute_address_generator_top");
    $finish;
  end

  // stimulus
  initial begin : stim
    longint unsigned volume;
    int sent;
    int phase;
    int count;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_count = 0;
    drain_hold_req = 1'b0;
    calm_tail = 1'b0;
    idle_on = 1'b1;
    cfg_dims = DIM_COUNT_RST;
    for (int d = 0; d < 4; d++) size_reg[d] = SIZE_RST;
    cfg_axis = AXIS_ORDER_RST;
    build_strides();

    // reset shape: single element, every beat is index 0 and last
    add_row(elem_row(32'hFFFF_FFFF, 1, 24'd0, 1));
    add_row(elem_row(32'h0000_0000, 1, 24'd0, 1));
    // one dimension of three, then wrap into a new tensor
    add_row(reg_row(REG_SIZE_DIM0, 3));
    add_row(elem_row(32'hA5A5_A5A5, 1, 24'd0, 0));
    add_row(elem_row(32'h5A5A_5A5A, 1, 24'd1, 0));
    add_row(elem_row(32'h1234_5678, 1, 24'd2, 1));
    add_row(elem_row(32'h8765_4321, 1, 24'd0, 0));
    // zero dimension count reads as one; the write restarts the tensor
    add_row(reg_row(REG_DIM_COUNT, 0));
    add_row(elem_row(32'hDEAD_BEEF, 1, 24'd0, 0));
    // 2x3 transpose: out index = i0 + 2*i1
    add_row(reg_row(REG_DIM_COUNT, 2));
    add_row(reg_row(REG_SIZE_DIM0, 2));
    add_row(reg_row(REG_SIZE_DIM1, 3));
    add_row(reg_row(REG_AXIS_ORDER, 8'hE1));
    add_row(elem_row(32'h0000_0001, 1, 24'd0, 0));
    add_row(elem_row(32'h0000_0002, 1, 24'd2, 0));
    add_row(elem_row(32'h0000_0004, 1, 24'd4, 0));
    add_row(elem_row(32'h0000_0008, 1, 24'd1, 0));
    add_row(elem_row(32'h0000_0010, 1, 24'd3, 0));
    add_row(elem_row(32'h0000_0020, 1, 24'd5, 1));
    // count above four, zero and saturating extents, axis order naming one dim only
    add_row(reg_row(REG_DIM_COUNT, 7));
    add_row(reg_row(REG_SIZE_DIM2, 0));
    add_row(reg_row(REG_SIZE_DIM3, 32'h1FF_FFFF));
    add_row(reg_row(REG_AXIS_ORDER, 8'h00));
    add_row(elem_row(32'hFFFF_0000, 0, 0, 0));
    add_row(elem_row(32'h0000_FFFF, 0, 0, 0));
    add_row(elem_row(32'hF0F0_F0F0, 0, 0, 0));
    add_row(reg_row(REG_AXIS_ORDER, 8'hFF));
    add_row(elem_row(32'h0F0F_0F0F, 0, 0, 0));
    add_row(elem_row(32'hCCCC_3333, 0, 0, 0));
    // extent exactly at the cap, fully reversed axis order
    add_row(reg_row(REG_SIZE_DIM3, 32'h100_0000));
    add_row(reg_row(REG_AXIS_ORDER, 8'h1B));
    add_row(elem_row(32'h3333_CCCC, 0, 0, 0));
    add_row(elem_row(32'h7FFF_FFFF, 0, 0, 0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_reg(directed_rows[i].reg_sel, directed_rows[i].value[SIZE_W-1:0]);
      end else begin
        if ($urandom_range(0, 5) == 0) idle_gap();
        offer(directed_rows[i].value, directed_rows[i].typed,
              directed_rows[i].want_index, directed_rows[i].want_last);
      end
    end

    // random shapes, each streamed through one or more whole tensors where small
    sent = 0;
    phase = 0;
    while (sent < RANDOM_BEATS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) write_reg(REG_DIM_COUNT, rand_dims());
      for (int d = 0; d < 4; d++) begin
        if ($urandom_range(0, 1)) write_reg(CFG_INDEX_W'(REG_SIZE_DIM0 + d), rand_extent());
      end
      if ($urandom_range(0, 1)) write_reg(REG_AXIS_ORDER, rand_axis());

      volume = 1;
      for (int d = 0; d < 4; d++) volume = volume * extent_of_dim(d);
      if (volume <= 48) count = int'(volume) * $urandom_range(1, 3) + $urandom_range(0, 1);
      else count = $urandom_range(8, 40);
      if (count < 4) count = 4;

      // long sink hold-off while beats keep coming
      if (phase == 2) drain_hold_req = 1'b1;

      for (int i = 0; i < count; i++) begin
        calm_tail = (sent >= CALM_AFTER);
        // source pause until every result is back
        if (phase == 4 && i == count / 2) begin
          @(negedge clk);
          s_tvalid = 1'b0;
          while (awaited.size() != 0) @(posedge clk);
        end
        if (idle_on && !calm_tail && $urandom_range(0, 5) == 0) idle_gap();
        offer($urandom, 0, 0, 0);
        sent++;
      end
      phase++;
    end

    // drain
    @(negedge clk);
    s_tvalid = 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && awaited.size() == 0) begin
      $display("PASS tensor_permute_address_generator_top");
    end else begin
      $display("FAIL tensor_permute_address_generator_top");
    end
    $finish;
  end

endmodule
